// ===== src/assert_macros.svh =====
// Assertion macros shared by the golden-section search RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define GSSC_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define GSSC_NEVER(name, clk, rst_n, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition");
`else
`define GSSC_ASSERT(name, clk, rst_n, prop)
`define GSSC_NEVER(name, clk, rst_n, expr)
`endif
`endif

// ===== src/gssc_pkg.sv =====
// Types and constants of the golden-section search controller.
package gssc_pkg;

    localparam int VW        = 32;
    localparam int ITER_W    = 16;
    localparam int TOL_W     = 16;
    localparam int TOL_FRAC  = 16;
    localparam int GOLD_FRAC = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;
    localparam int PW        = 2 * VW + 1;

    // 1 - 0.61803399 in Q0.32
    localparam logic [GOLD_FRAC-1:0] GOLD_C = 32'd1640531521;

    localparam logic       FUNC_START = 1'b0;
    localparam logic       FUNC_REPLY = 1'b1;

    localparam logic [1:0] KIND_REQUEST = 2'd0;
    localparam logic [1:0] KIND_ANSWER  = 2'd1;
    localparam logic [1:0] KIND_IGNORED = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_FIND_MAX  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER  = 2'd2;

    localparam logic [TOL_W-1:0]  TOL_RESET     = 16'd66;
    localparam logic [ITER_W-1:0] MAX_IT_RESET  = 16'd100;

    typedef enum logic [2:0] {
        PH_IDLE, PH_FIRST, PH_SECOND, PH_LEFT, PH_RIGHT
    } t_phase;

    typedef enum logic [3:0] {
        ST_IDLE, ST_MID, ST_REPLY, ST_SUM, ST_TMUL, ST_DECIDE,
        ST_GDIFF, ST_GMUL, ST_GADD
    } t_state;

    typedef struct packed {
        logic                 func;
        logic signed [VW-1:0] lower_bound;
        logic signed [VW-1:0] upper_bound;
        logic signed [VW-1:0] function_value;
    } t_in_word;

    typedef struct packed {
        logic [1:0]           kind;
        logic signed [VW-1:0] point;
        logic signed [VW-1:0] best_value;
        logic [ITER_W-1:0]    iterations_done;
    } t_out_word;

endpackage

// ===== src/golden_section_search_controller.sv =====
// Start word: the midpoint request passes MID, GDIFF, GMUL and GADD.
// Reply word: a continuing step passes SUM, TMUL, DECIDE, GDIFF, GMUL and GADD,
// an answer is sent from DECIDE, the second request or ignored reply from REPLY.
// One word at a time; one shared 33x32 multiplier serves point and threshold.
// Reset (synchronous, active low) clears sequencer, search phase, output valid
// and loads the configuration registers with their reset values.
`include "assert_macros.svh"

module golden_section_search_controller
    import gssc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_word             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_word            o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    function automatic logic better(input logic fmax,
                                    input logic signed [VW-1:0] p,
                                    input logic signed [VW-1:0] q);
        return fmax ? (p > q) : (p < q);
    endfunction

    function automatic logic [VW-1:0] mag(input logic signed [VW-1:0] x);
        return x[VW-1] ? VW'(-x) : VW'(x);
    endfunction

    t_state r_state, n_state;
    t_phase r_phase, n_phase;

    logic signed [VW-1:0] r_x0, r_x1, r_x2, r_x3, n_x0, n_x1, n_x2, n_x3;
    logic signed [VW-1:0] r_vl, r_vr, n_vl, n_vr;
    logic signed [VW-1:0] r_fval, n_fval;
    logic [ITER_W-1:0]    r_iter, n_iter;
    logic                 r_start, n_start;
    logic                 r_new_right, n_new_right;
    logic                 r_down, n_down;
    logic [VW-1:0]        r_dist, n_dist;
    logic [VW:0]          r_sum, n_sum;
    logic [VW-1:0]        r_width, n_width;
    logic [PW-1:0]        r_prod, n_prod;
    logic                 r_out_valid, n_out_valid;
    t_out_word            r_out, n_out;

    logic                 r_find_max;
    logic [TOL_W-1:0]     r_tol;
    logic [ITER_W-1:0]    r_max_it;

    logic                 in_fire, out_free;
    logic [VW:0]          mul_a;
    logic [GOLD_FRAC-1:0] mul_b;
    logic [PW-1:0]        mul_p;
    logic signed [VW-1:0] ga, gb, newp, mid_base;
    logic signed [VW:0]   gdiff, wdiff;
    logic [VW:0]          gdiff_abs, wdiff_abs, thresh;
    logic [VW-1:0]        step;
    logic                 go_on;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;
    assign in_fire     = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;

    // shared multiplier
    assign mul_a = (r_state == ST_TMUL) ? r_sum : {1'b0, r_dist};
    assign mul_b = (r_state == ST_TMUL) ? GOLD_FRAC'(r_tol) : GOLD_C;
    assign mul_p = PW'(mul_a) * PW'(mul_b);

    assign ga        = r_new_right ? r_x1 : r_x2;
    assign gb        = r_new_right ? r_x3 : r_x0;
    assign gdiff     = {gb[VW-1], gb} - {ga[VW-1], ga};
    assign gdiff_abs = gdiff[VW] ? (~gdiff + 1'b1) : gdiff;
    assign step      = r_prod[GOLD_FRAC +: VW];
    assign newp      = r_down ? (ga - step) : (ga + step);

    assign wdiff     = {r_x3[VW-1], r_x3} - {r_x0[VW-1], r_x0};
    assign wdiff_abs = wdiff[VW] ? (~wdiff + 1'b1) : wdiff;
    assign mid_base  = wdiff[VW] ? r_x3 : r_x0;

    assign thresh = r_prod[TOL_FRAC +: VW + 1];
    assign go_on  = (r_iter < r_max_it) && ({1'b0, r_width} > thresh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= PH_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x0        <= n_x0;
        r_x1        <= n_x1;
        r_x2        <= n_x2;
        r_x3        <= n_x3;
        r_vl        <= n_vl;
        r_vr        <= n_vr;
        r_fval      <= n_fval;
        r_iter      <= n_iter;
        r_start     <= n_start;
        r_new_right <= n_new_right;
        r_down      <= n_down;
        r_dist      <= n_dist;
        r_sum       <= n_sum;
        r_width     <= n_width;
        r_prod      <= n_prod;
        r_out       <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_find_max <= 1'b1;
            r_tol      <= TOL_RESET;
            r_max_it   <= MAX_IT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_FIND_MAX:  r_find_max <= i_cfg_data[0];
                CFG_TOLERANCE: r_tol      <= TOL_W'(i_cfg_data);
                CFG_MAX_ITER:  r_max_it   <= ITER_W'(i_cfg_data);
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_x0        = r_x0;
        n_x1        = r_x1;
        n_x2        = r_x2;
        n_x3        = r_x3;
        n_vl        = r_vl;
        n_vr        = r_vr;
        n_fval      = r_fval;
        n_iter      = r_iter;
        n_start     = r_start;
        n_new_right = r_new_right;
        n_down      = r_down;
        n_dist      = r_dist;
        n_sum       = r_sum;
        n_width     = r_width;
        n_prod      = r_prod;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;

        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    if (i_in_data.func == FUNC_START) begin
                        n_x0        = i_in_data.lower_bound;
                        n_x3        = i_in_data.upper_bound;
                        n_vl        = '0;
                        n_vr        = '0;
                        n_iter      = '0;
                        n_phase     = PH_FIRST;
                        n_start     = 1'b1;
                        n_new_right = 1'b1;
                        n_state     = ST_MID;
                    end else begin
                        n_fval  = i_in_data.function_value;
                        n_state = ST_REPLY;
                    end
                end
            end
            ST_MID: begin
                n_x1    = mid_base + VW'(wdiff_abs[VW:1]);
                n_state = ST_GDIFF;
            end
            ST_REPLY: begin
                case (r_phase)
                    PH_FIRST: begin
                        if (out_free) begin
                            n_vl        = r_fval;
                            n_phase     = PH_SECOND;
                            n_out_valid = 1'b1;
                            n_out       = '{KIND_REQUEST, r_x2, '0, '0};
                            n_state     = ST_IDLE;
                        end
                    end
                    PH_SECOND, PH_RIGHT: begin
                        n_vr    = r_fval;
                        n_state = ST_SUM;
                    end
                    PH_LEFT: begin
                        n_vl    = r_fval;
                        n_state = ST_SUM;
                    end
                    default: begin
                        if (out_free) begin
                            n_out_valid = 1'b1;
                            n_out       = '{KIND_IGNORED, '0, '0, '0};
                            n_state     = ST_IDLE;
                        end
                    end
                endcase
            end
            ST_SUM: begin
                n_sum   = {1'b0, mag(r_x1)} + {1'b0, mag(r_x2)};
                n_width = VW'(wdiff_abs);
                n_state = ST_TMUL;
            end
            ST_TMUL: begin
                n_prod  = mul_p;
                n_state = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (go_on) begin
                    n_iter  = r_iter + 1'b1;
                    n_start = 1'b0;
                    if (better(r_find_max, r_vr, r_vl)) begin
                        n_x0        = r_x1;
                        n_x1        = r_x2;
                        n_vl        = r_vr;
                        n_phase     = PH_RIGHT;
                        n_new_right = 1'b1;
                    end else begin
                        n_x3        = r_x2;
                        n_x2        = r_x1;
                        n_vr        = r_vl;
                        n_phase     = PH_LEFT;
                        n_new_right = 1'b0;
                    end
                    n_state = ST_GDIFF;
                end else if (out_free) begin
                    n_phase     = PH_IDLE;
                    n_out_valid = 1'b1;
                    if (better(r_find_max, r_vl, r_vr)) begin
                        n_out = '{KIND_ANSWER, r_x1, r_vl, r_iter};
                    end else begin
                        n_out = '{KIND_ANSWER, r_x2, r_vr, r_iter};
                    end
                    n_state = ST_IDLE;
                end
            end
            ST_GDIFF: begin
                n_down  = gdiff[VW];
                n_dist  = VW'(gdiff_abs);
                n_state = ST_GMUL;
            end
            ST_GMUL: begin
                n_prod  = mul_p;
                n_state = ST_GADD;
            end
            ST_GADD: begin
                if (out_free) begin
                    if (r_new_right) begin
                        n_x2 = newp;
                    end else begin
                        n_x1 = newp;
                    end
                    n_out_valid = 1'b1;
                    n_out       = '{KIND_REQUEST, (r_start ? r_x1 : newp), '0, '0};
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    `GSSC_ASSERT(a_busy_after_accept, i_clk, i_rst_n, (i_in_valid && o_in_ready) |=> !o_in_ready)
    `GSSC_ASSERT(a_emit_to_idle, i_clk, i_rst_n, $rose(r_out_valid) |-> (r_state == ST_IDLE))
    `GSSC_ASSERT(a_sum_phase, i_clk, i_rst_n, (r_state == ST_SUM) |-> (r_phase == PH_SECOND || r_phase == PH_LEFT || r_phase == PH_RIGHT))
    `GSSC_ASSERT(a_iter_counted, i_clk, i_rst_n, (r_state == ST_GDIFF && !r_start) |-> (r_iter != '0))
    `GSSC_NEVER(a_start_phase, i_clk, i_rst_n, r_state == ST_GADD && r_start && r_phase != PH_FIRST)

endmodule

// ===== sim/golden_search_checker.sv =====
// Watches the search controller's channels, predicts every output word and compares it.
`timescale 1ns / 100ps

module golden_search_checker
    import gssc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  t_in_word             i_in_data,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  t_out_word            i_out_data,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    output int                   o_errors,
    output int                   o_pending
);

    localparam longint GOLD_MUL = longint'(GOLD_C);

    logic              max_mode;
    logic [TOL_W-1:0]  tol_q16;
    logic [ITER_W-1:0] iter_limit;

    longint            lo_end, left_pt, right_pt, hi_end;
    longint            left_val, right_val;
    logic [ITER_W-1:0] narrow_count;
    t_phase            seek_phase;

    t_out_word         predicted_words[$];

    function automatic longint magnitude(longint x);
        return (x < 0) ? -x : x;
    endfunction

    // a + C*|b-a| toward b, step truncated toward a
    function automatic longint golden_point(longint a, longint b);
        longint span;
        span = magnitude(b - a);
        if (b >= a)
            return a + ((span * GOLD_MUL) >>> 32);
        return a - ((span * GOLD_MUL) >>> 32);
    endfunction

    function automatic bit better(longint p, longint q);
        return max_mode ? (p > q) : (p < q);
    endfunction

    function automatic t_out_word narrow_bracket();
        t_out_word r;
        longint    width;
        longint    thresh;
        r      = '0;
        width  = magnitude(hi_end - lo_end);
        thresh = ((magnitude(left_pt) + magnitude(right_pt)) * longint'(tol_q16)) >>> TOL_FRAC;
        if (narrow_count < iter_limit && width > thresh) begin
            narrow_count = narrow_count + 1'b1;
            r.kind = KIND_REQUEST;
            if (better(right_val, left_val)) begin
                lo_end     = left_pt;
                left_pt    = right_pt;
                right_pt   = golden_point(right_pt, hi_end);
                left_val   = right_val;
                seek_phase = PH_RIGHT;
                r.point    = right_pt[VW-1:0];
            end else begin
                hi_end     = right_pt;
                right_pt   = left_pt;
                left_pt    = golden_point(left_pt, lo_end);
                right_val  = left_val;
                seek_phase = PH_LEFT;
                r.point    = left_pt[VW-1:0];
            end
        end else begin
            seek_phase        = PH_IDLE;
            r.kind            = KIND_ANSWER;
            r.iterations_done = narrow_count;
            if (better(left_val, right_val)) begin
                r.point      = left_pt[VW-1:0];
                r.best_value = left_val[VW-1:0];
            end else begin
                r.point      = right_pt[VW-1:0];
                r.best_value = right_val[VW-1:0];
            end
        end
        return r;
    endfunction

    function automatic t_out_word search_step(t_in_word w);
        t_out_word r;
        longint    lo;
        longint    hi;
        longint    v;
        r = '0;
        if (w.func == FUNC_START) begin
            lo           = $signed(w.lower_bound);
            hi           = $signed(w.upper_bound);
            lo_end       = lo;
            hi_end       = hi;
            left_pt      = (hi >= lo) ? lo + (hi - lo) / 2 : hi + (lo - hi) / 2;
            right_pt     = golden_point(left_pt, hi_end);
            left_val     = 0;
            right_val    = 0;
            narrow_count = '0;
            seek_phase   = PH_FIRST;
            r.kind       = KIND_REQUEST;
            r.point      = left_pt[VW-1:0];
            return r;
        end
        v = $signed(w.function_value);
        case (seek_phase)
            PH_FIRST: begin
                left_val   = v;
                seek_phase = PH_SECOND;
                r.kind     = KIND_REQUEST;
                r.point    = right_pt[VW-1:0];
            end
            PH_SECOND, PH_RIGHT: begin
                right_val = v;
                r         = narrow_bracket();
            end
            PH_LEFT: begin
                left_val = v;
                r        = narrow_bracket();
            end
            default: r.kind = KIND_IGNORED;
        endcase
        return r;
    endfunction

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            o_errors++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_out_word want;
        if (!i_rst_n) begin
            max_mode     = 1'b1;
            tol_q16      = TOL_RESET;
            iter_limit   = MAX_IT_RESET;
            lo_end       = 0;
            left_pt      = 0;
            right_pt     = 0;
            hi_end       = 0;
            left_val     = 0;
            right_val    = 0;
            narrow_count = '0;
            seek_phase   = PH_IDLE;
            predicted_words.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (predicted_words.size() == 0) begin
                    $error("unexpected output word: kind %0d point %0d",
                           i_out_data.kind, $signed(i_out_data.point));
                    o_errors++;
                end else begin
                    want = predicted_words.pop_front();
                    check_field("kind", want.kind, i_out_data.kind);
                    check_field("point", $signed(want.point), $signed(i_out_data.point));
                    check_field("best_value", $signed(want.best_value),
                                $signed(i_out_data.best_value));
                    check_field("iterations_done", want.iterations_done,
                                i_out_data.iterations_done);
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_FIND_MAX:  max_mode   = i_cfg_data[0];
                    CFG_TOLERANCE: tol_q16    = i_cfg_data;
                    CFG_MAX_ITER:  iter_limit = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                predicted_words.push_back(search_step(i_in_data));
        end
        o_pending = predicted_words.size();
    end

endmodule

// ===== sim/tb.sv =====
// Testbench top: drives searches, replies and register writes into the controller.
`timescale 1ns / 100ps

module tb;
    import gssc_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    t_in_word             in_data;
    logic                 out_valid;
    logic                 out_ready;
    t_out_word            out_data;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;

    int                   errors;
    int                   pending;
    int                   n_sent = 0;
    int                   n_taken = 0;
    int                   n_answers = 0;
    bit                   idle_on = 1'b1;
    bit                   hold_out = 1'b0;
    bit                   hold_done = 1'b0;
    logic [ITER_W-1:0]    iter_cap = MAX_IT_RESET;
    logic signed [VW-1:0] last_value = '0;

    golden_section_search_controller dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    golden_search_checker chk (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            n_taken <= n_taken + 1;
            if (out_data.kind == KIND_ANSWER)
                n_answers <= n_answers + 1;
        end
    end

    initial begin
        out_ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_out && !hold_done) begin
                out_ready = 1'b0;
                repeat (300) @(negedge clk);
                hold_done = 1'b1;
                out_ready = 1'b1;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                out_ready = 1'b0;
                repeat ($urandom_range(1, 9) - 1) @(negedge clk);
            end else begin
                out_ready = 1'b1;
            end
        end
    end

    initial begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic push_word(input t_in_word w);
        @(negedge clk);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clk);
        end
        in_valid = 1'b1;
        in_data  = w;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        n_sent++;
    endtask

    task automatic settle();
        @(negedge clk);
        in_valid = 1'b0;
        while (n_taken != n_sent) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
        settle();
        repeat (8) @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
        if (idx == CFG_MAX_ITER)
            iter_cap = val;
    endtask

    function automatic logic signed [VW-1:0] pick_value(input logic signed [VW-1:0] prev);
        case ($urandom_range(0, 9))
            0:       return {1'b1, {(VW-1){1'b0}}};
            1:       return {1'b0, {(VW-1){1'b1}}};
            2:       return '0;
            3, 4:    return prev;
            default: return $urandom;
        endcase
    endfunction

    task automatic open_search(input logic signed [VW-1:0] lo, input logic signed [VW-1:0] hi);
        t_in_word w;
        w.func           = FUNC_START;
        w.lower_bound    = lo;
        w.upper_bound    = hi;
        w.function_value = $urandom;
        push_word(w);
    endtask

    // replies until the answer comes back or the budget runs out
    task automatic feed_replies(input int budget, input bit lockstep);
        t_in_word w;
        int       seen;
        int       remaining;
        seen      = n_answers;
        remaining = budget;
        if (lockstep)
            settle();
        while (remaining > 0 && n_answers == seen) begin
            last_value       = pick_value(last_value);
            w.func           = FUNC_REPLY;
            w.lower_bound    = $urandom;
            w.upper_bound    = $urandom;
            w.function_value = last_value;
            push_word(w);
            if (lockstep)
                settle();
            remaining--;
        end
    endtask

    task automatic stray_reply();
        t_in_word w;
        w.func           = FUNC_REPLY;
        w.lower_bound    = $urandom;
        w.upper_bound    = $urandom;
        w.function_value = $urandom;
        push_word(w);
        settle();
    endtask

    initial begin
        logic signed [VW-1:0] lo;
        logic signed [VW-1:0] hi;
        logic [TOL_W-1:0]     tol;
        logic [ITER_W-1:0]    lim;
        int                   target;
        int                   round;
        int                   cap;
        bit                   lock;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        stray_reply();
        write_reg(CFG_MAX_ITER, 16'd0);
        open_search(32'sh8000_0000, 32'sh7fff_ffff);
        feed_replies(3, 1'b1);
        write_reg(CFG_FIND_MAX, 16'd0);
        write_reg(CFG_MAX_ITER, 16'd3);
        open_search(32'sh7fff_ffff, 32'sh8000_0000);
        feed_replies(8, 1'b1);
        write_reg(CFG_FIND_MAX, 16'hffff);
        write_reg(CFG_TOLERANCE, 16'hffff);
        open_search(-32'sh0005_0000, 32'sh0005_0000);
        feed_replies(4, 1'b1);
        write_reg(CFG_TOLERANCE, 16'd0);
        write_reg(CFG_MAX_ITER, 16'd20);
        open_search(32'sh0000_0000, 32'sh0064_0000);
        feed_replies(1, 1'b1);
        open_search(32'sh0000_0007, 32'sh0000_0007);
        feed_replies(4, 1'b1);
        open_search(32'sh0010_0000, -32'sh0003_0000);
        feed_replies(1, 1'b1);
        write_reg(CFG_MAX_ITER, 16'd2);
        write_reg(CFG_SPARE, 16'hffff);
        feed_replies(10, 1'b1);

        target = n_sent + 750;
        round  = 0;
        while (n_sent < target) begin
            case (round)
                0: begin
                    tol = '0;
                    lim = ITER_W'($urandom_range(0, 8));
                end
                1: begin
                    tol = 16'hffff;
                    lim = 16'hffff;
                end
                default: begin
                    case ($urandom_range(0, 4))
                        0:       tol = TOL_RESET;
                        1:       tol = TOL_W'($urandom);
                        2:       tol = '0;
                        default: tol = TOL_W'($urandom_range(1, 600));
                    endcase
                    lim = ($urandom_range(0, 7) == 0) ? 16'hffff
                                                      : ITER_W'($urandom_range(0, 20));
                end
            endcase
            write_reg(CFG_FIND_MAX, {15'($urandom), 1'($urandom_range(0, 1))});
            write_reg(CFG_TOLERANCE, tol);
            write_reg(CFG_MAX_ITER, lim);
            if ($urandom_range(0, 5) == 0)
                write_reg(CFG_SPARE, CFG_DAT_W'($urandom));
            if (round == 2)
                hold_out = 1'b1;
            repeat ($urandom_range(3, 8)) begin
                idle_on = (n_sent < target - 100) && ($urandom_range(0, 4) != 0);
                if ($urandom_range(0, 9) == 0)
                    stray_reply();
                case ($urandom_range(0, 5))
                    0, 1: begin
                        lo = $urandom;
                        hi = $urandom;
                    end
                    2: begin
                        lo = 32'sh8000_0000;
                        hi = 32'sh7fff_ffff;
                        if ($urandom_range(0, 1))
                            {lo, hi} = {hi, lo};
                    end
                    3: begin
                        lo = $urandom;
                        hi = lo;
                    end
                    default: begin
                        lo = $signed(VW'($urandom)) >>> 12;
                        hi = lo + VW'($urandom_range(1, 1 << 20));
                    end
                endcase
                cap = (iter_cap > 40) ? $urandom_range(20, 60)
                                      : int'(iter_cap) + 2 + $urandom_range(0, 1);
                if ($urandom_range(0, 7) == 0)
                    cap = $urandom_range(0, cap);
                lock = (hold_out && !hold_done) ? 1'b0 : ($urandom_range(0, 3) != 0);
                open_search(lo, hi);
                feed_replies(cap, lock);
            end
            round++;
        end

        settle();
        repeat (20) @(negedge clk);
        if (errors == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
